FILE: design/srev_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and default line lengths of the reverb unit
package srev_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LINE_W      = 20;
   localparam int COEF_W      = 17;
   localparam int FB_W        = 16;
   localparam int CSR_INDEX_W = 8;

   localparam int COMB_COUNT     = 4;
   localparam int COMB_WR_LAG    = 2;
   localparam int ALLPASS_WR_LAG = 1;

   localparam int DEF_COMB_DELAY_A    = 1116;
   localparam int DEF_COMB_DELAY_B    = 1188;
   localparam int DEF_COMB_DELAY_C    = 1277;
   localparam int DEF_COMB_DELAY_D    = 1356;
   localparam int DEF_ALLPASS_DELAY_A = 556;
   localparam int DEF_ALLPASS_DELAY_B = 441;

   localparam int Q16_ONE    = 65536;
   localparam int Q16_HALF   = 32768;
   localparam int Q16_SHIFT  = 16;
   localparam int FB_BASE    = 39322;
   localparam int FB_SPAN    = 19661;
   localparam int COMB_SHIFT = 2;
   localparam int COMB_ROUND = 2;

   localparam int LINE_MAX   = 524287;
   localparam int LINE_MIN   = -524288;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOM_SCALE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WET_MIX    = CSR_INDEX_W'(1);

   typedef logic signed [LINE_W-1:0] line_word_type;

   typedef struct packed {
      logic step;
      logic rd_valid;
      logic wr_valid;
   } line_ctl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } result_type;

endpackage

FILE: design/srev_delay_line.sv
`timescale 1ns / 1ps
// one circular delay line: memory, position counter, write bypass and reset clearing sweep
module srev_delay_line #(
   parameter int DEPTH  = srev_pkg::DEF_COMB_DELAY_A,
   parameter int WR_LAG = srev_pkg::COMB_WR_LAG
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srev_pkg::line_ctl_type  ctl,
   input  srev_pkg::line_word_type wr_data,
   output srev_pkg::line_word_type rd_data,
   output logic                    busy
);
   import srev_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   line_word_type mem [DEPTH];
   logic [AW-1:0] addr_ff [WR_LAG];
   logic [AW-1:0] pos_ff, pos_in, clr_cnt_ff, wr_addr;
   logic          clr_ff, byp_ff, wr_en;
   line_word_type rd_ff, byp_data_ff;

   assign wr_addr = addr_ff[WR_LAG-1];
   assign wr_en   = ctl.step && ctl.wr_valid;
   assign pos_in  = (pos_ff == LAST) ? '0 : pos_ff + AW'(1);
   assign rd_data = byp_ff ? byp_data_ff : rd_ff;
   assign busy    = clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         pos_ff     <= '0;
         byp_ff     <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST) begin
               clr_ff <= 1'b0;
            end
         end
         if (ctl.step && ctl.rd_valid) begin
            pos_ff <= pos_in;
         end
         if (ctl.step) begin
            byp_ff <= wr_en && (wr_addr == pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.step) begin
         rd_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         byp_data_ff <= wr_data;
         addr_ff[0]  <= pos_ff;
         for (int i = 1; i < WR_LAG; i++) begin
            addr_ff[i] <= addr_ff[i-1];
         end
      end
   end

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !ctl.rd_valid && !ctl.wr_valid)
      else $error("delay line accessed during clearing sweep");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST)
      else $error("delay line position beyond its length");

endmodule

FILE: design/srev_out_skid.sv
`timescale 1ns / 1ps
// output register with a one-item skid stage that frees the pipeline from rsp_ready
module srev_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  srev_pkg::result_type in_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srev_pkg::result_type rsp_item
);
   import srev_pkg::*;

   logic       rsp_valid_ff, skid_valid_ff, rsp_free;
   result_type rsp_item_ff, skid_item_ff;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign in_ready  = !skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= in_valid;
         end
      end else if (!skid_valid_ff && in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_item_ff <= skid_valid_ff ? skid_item_ff : in_item;
      end else if (!skid_valid_ff) begin
         skid_item_ff <= in_item;
      end
   end

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_item_ff))
      else $error("skid item lost while output stalled");

endmodule

FILE: design/schroeder_reverb_unit.sv
`timescale 1ns / 1ps
// top level of the Schroeder reverb unit: config registers and the sample pipeline
//
// Four feedback comb lines are averaged, passed through two allpass sections and
// cross-faded with the dry sample. The unit takes one item per clock cycle while
// the skid stage is empty and no clearing sweep runs; the pace is set by
// the delay line memories, each of which does one read and one write per cycle.
// A stalled output is absorbed by a one-item skid stage before req_ready drops.
// After reset the delay lines are cleared in a sweep over every entry; req_ready
// stays low until the longest line (1356 entries with the default lengths) is
// cleared. The room scale (index 0) and wet mix (index 1) registers should
// only be written while no item is in flight; values above 65536 act as 65536,
// and other indexes are ignored.
module schroeder_reverb_unit #(
   parameter int COMB_DELAY_A    = srev_pkg::DEF_COMB_DELAY_A,
   parameter int COMB_DELAY_B    = srev_pkg::DEF_COMB_DELAY_B,
   parameter int COMB_DELAY_C    = srev_pkg::DEF_COMB_DELAY_C,
   parameter int COMB_DELAY_D    = srev_pkg::DEF_COMB_DELAY_D,
   parameter int ALLPASS_DELAY_A = srev_pkg::DEF_ALLPASS_DELAY_A,
   parameter int ALLPASS_DELAY_B = srev_pkg::DEF_ALLPASS_DELAY_B
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [srev_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                    req_last_in_block,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [srev_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                                    rsp_block_end,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [srev_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [srev_pkg::COEF_W-1:0]             csr_data
);
   import srev_pkg::*;

   localparam int COMB_DELAYS [COMB_COUNT] =
      '{COMB_DELAY_A, COMB_DELAY_B, COMB_DELAY_C, COMB_DELAY_D};
   localparam int WIDE   = LINE_W + 2;
   localparam int PROD_W = LINE_W + FB_W + 1;
   localparam int MIXD_W = SAMPLE_W + COEF_W + 1;
   localparam int MIXW_W = LINE_W + COEF_W + 1;
   localparam int SUM_W  = MIXW_W + 1;

   function automatic line_word_type sat20(input logic signed [WIDE-1:0] v);
      if (v > WIDE'(LINE_MAX)) begin
         return LINE_W'(LINE_MAX);
      end else if (v < WIDE'(LINE_MIN)) begin
         return LINE_W'(LINE_MIN);
      end
      return LINE_W'(v);
   endfunction

   function automatic logic signed [WIDE-1:0] rnd1(input line_word_type v);
      return (WIDE'(v) + WIDE'(1)) >>> 1;
   endfunction

   // handshake and control
   logic pipe_step, req_accept, clearing;
   logic [COMB_COUNT-1:0] comb_busy;
   logic [1:0] ap_busy;
   line_ctl_type comb_ctl, apa_ctl, apb_ctl;

   // configuration
   logic [FB_W-1:0]   fb_ff, fb_in;
   logic [COEF_W-1:0] wet_gain_ff, dry_gain_ff, csr_clamped;
   logic [31:0]       fb_prod;

   // pipeline
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic signed [SAMPLE_W-1:0] dry1_ff, dry2_ff, dry3_ff, dry4_ff;
   line_word_type comb_rd [COMB_COUNT];
   line_word_type comb_wr [COMB_COUNT];
   logic signed [PROD_W-1:0] comb_prod_in [COMB_COUNT];
   logic signed [PROD_W-1:0] comb_prod_ff [COMB_COUNT];
   logic signed [WIDE-1:0] comb_sum_in, comb_sum_ff;
   line_word_type wet2, apa_rd, apa_wr, apa_out_in, apa3_ff;
   line_word_type apb_rd, apb_wr, apb_out_in, wet4_ff;
   logic signed [MIXD_W-1:0] mix_dry_in, mix_dry_ff;
   logic signed [MIXW_W-1:0] mix_wet_in, mix_wet_ff;
   logic signed [SUM_W-1:0]  mix_sum, mix_shift;
   logic signed [SAMPLE_W-1:0] out_sample;
   result_type out_item, rsp_item;

   assign clearing   = (|comb_busy) || (|ap_busy);
   assign req_ready  = pipe_step && !clearing;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign comb_ctl = '{step: pipe_step, rd_valid: req_accept, wr_valid: v2_ff};
   assign apa_ctl  = '{step: pipe_step, rd_valid: v1_ff, wr_valid: v2_ff};
   assign apb_ctl  = '{step: pipe_step, rd_valid: v2_ff, wr_valid: v3_ff};

   // configuration registers
   always_comb begin
      csr_clamped = (csr_data > COEF_W'(Q16_ONE)) ? COEF_W'(Q16_ONE) : csr_data;
      fb_prod     = 32'(FB_SPAN) * 32'(csr_clamped) + 32'(Q16_HALF);
      fb_in       = FB_W'(32'(FB_BASE) + (fb_prod >> Q16_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff       <= FB_W'(FB_BASE);
         wet_gain_ff <= '0;
         dry_gain_ff <= COEF_W'(Q16_ONE);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROOM_SCALE: begin
               fb_ff <= fb_in;
            end
            CSR_WET_MIX: begin
               wet_gain_ff <= csr_clamped;
               dry_gain_ff <= COEF_W'(Q16_ONE) - csr_clamped;
            end
            default: begin
            end
         endcase
      end
   end

   // delay lines
   for (genvar g = 0; g < COMB_COUNT; g++) begin : g_comb
      srev_delay_line #(
         .DEPTH  (COMB_DELAYS[g]),
         .WR_LAG (COMB_WR_LAG)
      ) u_line (
         .clock   (clock),
         .reset   (reset),
         .ctl     (comb_ctl),
         .wr_data (comb_wr[g]),
         .rd_data (comb_rd[g]),
         .busy    (comb_busy[g])
      );
   end

   srev_delay_line #(
      .DEPTH  (ALLPASS_DELAY_A),
      .WR_LAG (ALLPASS_WR_LAG)
   ) u_allpass_a (
      .clock   (clock),
      .reset   (reset),
      .ctl     (apa_ctl),
      .wr_data (apa_wr),
      .rd_data (apa_rd),
      .busy    (ap_busy[0])
   );

   srev_delay_line #(
      .DEPTH  (ALLPASS_DELAY_B),
      .WR_LAG (ALLPASS_WR_LAG)
   ) u_allpass_b (
      .clock   (clock),
      .reset   (reset),
      .ctl     (apb_ctl),
      .wr_data (apb_wr),
      .rd_data (apb_rd),
      .busy    (ap_busy[1])
   );

   // stage 1: comb feedback products and comb sum
   always_comb begin
      comb_sum_in = '0;
      for (int k = 0; k < COMB_COUNT; k++) begin
         comb_prod_in[k] = PROD_W'(comb_rd[k]) * PROD_W'($signed({1'b0, fb_ff}));
         comb_sum_in     = comb_sum_in + WIDE'(comb_rd[k]);
      end
   end

   // stage 2: comb write back, average, first allpass
   always_comb begin
      for (int k = 0; k < COMB_COUNT; k++) begin
         comb_wr[k] = sat20(WIDE'(dry2_ff)
            + WIDE'((comb_prod_ff[k] + PROD_W'(Q16_HALF)) >>> Q16_SHIFT));
      end
      wet2       = LINE_W'((comb_sum_ff + WIDE'(COMB_ROUND)) >>> COMB_SHIFT);
      apa_wr     = sat20(WIDE'(wet2) + rnd1(apa_rd));
      apa_out_in = sat20(WIDE'(apa_rd) - rnd1(wet2));
   end

   // stage 3: second allpass
   always_comb begin
      apb_wr     = sat20(WIDE'(apa3_ff) + rnd1(apb_rd));
      apb_out_in = sat20(WIDE'(apb_rd) - rnd1(apa3_ff));
   end

   // stage 4: dry and wet gains
   assign mix_dry_in = MIXD_W'(dry4_ff) * MIXD_W'($signed({1'b0, dry_gain_ff}));
   assign mix_wet_in = MIXW_W'(wet4_ff) * MIXW_W'($signed({1'b0, wet_gain_ff}));

   // stage 5: cross-fade sum, rounding and output clamp
   always_comb begin
      mix_sum   = SUM_W'(mix_dry_ff) + SUM_W'(mix_wet_ff) + SUM_W'(Q16_HALF);
      mix_shift = mix_sum >>> Q16_SHIFT;
      if (mix_shift > SUM_W'(SAMPLE_MAX)) begin
         out_sample = SAMPLE_W'(SAMPLE_MAX);
      end else if (mix_shift < SUM_W'(SAMPLE_MIN)) begin
         out_sample = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         out_sample = SAMPLE_W'(mix_shift);
      end
      out_item = '{sample: out_sample, block_end: last5_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (pipe_step) begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_step) begin
         dry1_ff      <= req_sample_in;
         last1_ff     <= req_last_in_block;
         comb_prod_ff <= comb_prod_in;
         comb_sum_ff  <= comb_sum_in;
         dry2_ff      <= dry1_ff;
         last2_ff     <= last1_ff;
         apa3_ff      <= apa_out_in;
         dry3_ff      <= dry2_ff;
         last3_ff     <= last2_ff;
         wet4_ff      <= apb_out_in;
         dry4_ff      <= dry3_ff;
         last4_ff     <= last3_ff;
         mix_dry_ff   <= mix_dry_in;
         mix_wet_ff   <= mix_wet_in;
         last5_ff     <= last4_ff;
      end
   end

   srev_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (pipe_step),
      .in_item   (out_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_sample_out = rsp_item.sample;
   assign rsp_block_end  = rsp_item.block_end;

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff))
      else $error("item in flight during delay line clearing");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_step |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff}))
      else $error("pipeline moved while stalled");

endmodule

FILE: sim/tb_schroeder_reverb_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the reverb unit: directed table, random and loud soak items
module tb_schroeder_reverb_unit;
   import srev_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 120;
   localparam int SOAK_ITEMS     = 220;
   localparam int ALLPASS_COUNT  = 2;

   localparam int COMB_LEN [COMB_COUNT] = '{DEF_COMB_DELAY_A, DEF_COMB_DELAY_B,
                                            DEF_COMB_DELAY_C, DEF_COMB_DELAY_D};
   localparam int ALLPASS_LEN [ALLPASS_COUNT] = '{DEF_ALLPASS_DELAY_A, DEF_ALLPASS_DELAY_B};

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = CSR_INDEX_W'(255);

   localparam logic [COEF_W-1:0] COEF_ZERO  = '0;
   localparam logic [COEF_W-1:0] COEF_HALF  = COEF_W'(Q16_HALF);
   localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(Q16_ONE);
   localparam logic [COEF_W-1:0] COEF_FULL  = '1;

   localparam logic signed [SAMPLE_W-1:0] PEAK_POS = SAMPLE_W'(SAMPLE_MAX);
   localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = SAMPLE_W'(SAMPLE_MIN);

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_W-1:0]     index;
      logic [COEF_W-1:0]          data;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic                       fixed;
      logic signed [SAMPLE_W-1:0] fixed_out;
   } stim_row_type;

   localparam int ROW_COUNT = 28;

   stim_row_type directed_rows [ROW_COUNT] = '{
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sd0,      1'b0, 1'b1, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_POS,    1'b0, 1'b1, PEAK_POS},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_NEG,    1'b0, 1'b1, PEAK_NEG},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  -16'sd1,     1'b0, 1'b1, -16'sd1},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sd1,      1'b1, 1'b1, 16'sd1},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sh5555,   1'b0, 1'b1, 16'sh5555},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'shAAAA,   1'b1, 1'b1, 16'shAAAA},
      '{ROW_WRITE, CSR_ROOM_SCALE,  COEF_UNITY, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_WET_MIX,     COEF_UNITY, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_POS,    1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_NEG,    1'b1, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_ROOM_SCALE,  COEF_FULL,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_WET_MIX,     COEF_FULL,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_POS,    1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_NEG,    1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sd12345,  1'b1, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_WET_MIX,     COEF_HALF,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_POS,    1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  -16'sd3,     1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_WET_MIX,     COEF_ZERO,  16'sd0,      1'b0, 1'b0, 16'sd0},
      // writes to unused indexes must leave the dry path untouched
      '{ROW_WRITE, CSR_SPARE_FIRST, COEF_UNITY, 16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, CSR_SPARE_LAST,  COEF_FULL,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_NEG,    1'b0, 1'b1, PEAK_NEG},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  PEAK_POS,    1'b1, 1'b1, PEAK_POS},
      '{ROW_WRITE, CSR_ROOM_SCALE,  COEF_ZERO,  16'sd0,      1'b0, 1'b0, 16'sd0},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  -16'sd2,     1'b0, 1'b1, -16'sd2},
      '{ROW_ITEM,  CSR_ROOM_SCALE,  COEF_ZERO,  16'sd7,      1'b1, 1'b1, 16'sd7}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_sample_in;
   logic                          req_last_in_block;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_W-1:0]    rsp_sample_out;
   logic                          rsp_block_end;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [COEF_W-1:0]             csr_data;

   // model state of the delay lines and registers
   line_word_type comb_mem [COMB_COUNT][DEF_COMB_DELAY_D];
   line_word_type allpass_mem [ALLPASS_COUNT][DEF_ALLPASS_DELAY_A];
   int            comb_pos [COMB_COUNT];
   int            allpass_pos [ALLPASS_COUNT];
   logic [COEF_W-1:0] room_setting;
   logic [COEF_W-1:0] mix_setting;

   result_type pending_outputs [$];
   int         mismatch_count;
   int         quiet_cycles;

   logic                       item_fixed;
   logic signed [SAMPLE_W-1:0] item_fixed_out;
   bit                         req_idle_on;
   bit                         rsp_idle_on;
   int                         holdoff_requests;

   schroeder_reverb_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .req_last_in_block (req_last_in_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end     (rsp_block_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint clamp_unity(input logic [COEF_W-1:0] v);
      return (v > Q16_ONE) ? longint'(Q16_ONE) : longint'(v);
   endfunction

   function automatic result_type reverb_step(input logic signed [SAMPLE_W-1:0] dry,
                                              input logic last);
      result_type res;
      longint     fb;
      longint     mix;
      longint     acc;
      longint     wet;
      longint     tap;
      fb  = FB_BASE + round_shift(longint'(FB_SPAN) * clamp_unity(room_setting), Q16_SHIFT);
      mix = clamp_unity(mix_setting);
      acc = 0;
      for (int k = 0; k < COMB_COUNT; k++) begin
         tap = comb_mem[k][comb_pos[k]];
         comb_mem[k][comb_pos[k]] = LINE_W'(clamp(longint'(dry) + round_shift(tap * fb, Q16_SHIFT),
                                                  LINE_MIN, LINE_MAX));
         comb_pos[k] = (comb_pos[k] + 1 == COMB_LEN[k]) ? 0 : comb_pos[k] + 1;
         acc += tap;
      end
      wet = round_shift(acc, COMB_SHIFT);
      for (int k = 0; k < ALLPASS_COUNT; k++) begin
         tap = allpass_mem[k][allpass_pos[k]];
         allpass_mem[k][allpass_pos[k]] = LINE_W'(clamp(wet + round_shift(tap, 1),
                                                        LINE_MIN, LINE_MAX));
         wet = clamp(tap - round_shift(wet, 1), LINE_MIN, LINE_MAX);
         allpass_pos[k] = (allpass_pos[k] + 1 == ALLPASS_LEN[k]) ? 0 : allpass_pos[k] + 1;
      end
      res.sample = SAMPLE_W'(clamp(round_shift(longint'(dry) * (Q16_ONE - mix) + wet * mix,
                                               Q16_SHIFT), SAMPLE_MIN, SAMPLE_MAX));
      res.block_end = last;
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         return SAMPLE_W'($urandom);
      end else if (pick < 13) begin
         case ($urandom_range(0, 3))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return 16'sd0;
            default: return -16'sd1;
         endcase
      end else if (pick < 17) begin
         return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      end else if ($urandom_range(0, 1) == 0) begin
         return PEAK_POS - SAMPLE_W'($urandom_range(0, 255));
      end else begin
         return PEAK_NEG + SAMPLE_W'($urandom_range(0, 255));
      end
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 5))
         0: return COEF_ZERO;
         1: return COEF_UNITY;
         2: return COEF_FULL;
         3: return COEF_W'($urandom_range(0, Q16_ONE));
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [COEF_W-1:0] data);
      req_valid = 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic last,
                              input logic fixed, input logic signed [SAMPLE_W-1:0] fixed_out);
      req_valid         = 1'b1;
      req_sample_in     = sample;
      req_last_in_block = last;
      item_fixed        = fixed;
      item_fixed_out    = fixed_out;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_in     = '0;
      req_last_in_block = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      item_fixed        = 1'b0;
      item_fixed_out    = '0;
      req_idle_on       = 1'b1;
      rsp_idle_on       = 1'b1;
      holdoff_requests  = 0;
      room_setting      = '0;
      mix_setting       = '0;
      mismatch_count    = 0;
      foreach (comb_mem[k, i]) comb_mem[k][i] = '0;
      foreach (allpass_mem[k, i]) allpass_mem[k][i] = '0;
      foreach (comb_pos[k]) comb_pos[k] = 0;
      foreach (allpass_pos[k]) allpass_pos[k] = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            write_reg(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_sample(directed_rows[r].sample, directed_rows[r].last,
                        directed_rows[r].fixed, directed_rows[r].fixed_out);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_idle_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         // an early loud stretch comes back out of the comb lines late in the run
         if (phase == 0) begin
            write_reg(CSR_ROOM_SCALE, COEF_FULL);
            write_reg(CSR_WET_MIX, COEF_UNITY);
            for (int n = 0; n < 2 * SOAK_ITEMS; n++) begin
               send_sample((n < SOAK_ITEMS) ? PEAK_POS - SAMPLE_W'($urandom_range(0, 15))
                                            : PEAK_NEG + SAMPLE_W'($urandom_range(0, 15)),
                           $urandom_range(0, 63) == 0, 1'b0, '0);
            end
         end
         write_reg(CSR_ROOM_SCALE, random_coef());
         write_reg(CSR_WET_MIX, random_coef());
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      COEF_W'($urandom));
         end
         if (phase == 2) holdoff_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(random_sample(), $urandom_range(0, 15) == 0, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_schroeder_reverb_unit passed");
      end else begin
         $display("tb_schroeder_reverb_unit failed");
      end
      $finish;
   end

   initial begin : receiver
      int holdoff_left;
      int stall_left;
      int holdoffs_served;
      holdoff_left    = 0;
      stall_left      = 0;
      holdoffs_served = 0;
      rsp_ready       = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_left > 0) begin
            rsp_ready = 1'b0;
            holdoff_left--;
         end else if (holdoffs_served != holdoff_requests) begin
            holdoffs_served++;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_ready    = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ready  = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_outputs
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROOM_SCALE) begin
               room_setting = csr_data;
            end else if (csr_index == CSR_WET_MIX) begin
               mix_setting = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            want = reverb_step(req_sample_in, req_last_in_block);
            if (item_fixed) want.sample = item_fixed_out;
            pending_outputs.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual sample_out %0d block_end %0b",
                        $time, rsp_sample_out, rsp_block_end);
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_sample_out !== want.sample) begin
                  mismatch_count++;
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, want.sample, rsp_sample_out);
               end
               if (rsp_block_end !== want.block_end) begin
                  mismatch_count++;
                  $display("%0t: block_end mismatch, expected %0b actual %0b",
                           $time, want.block_end, rsp_block_end);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_schroeder_reverb_unit failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
